// ----- sv/lhwn_pkg.sv -----
// Shared types, constants and helper functions for the line hash normalizer.
package lhwn_pkg;

	// Character handling
	localparam int CHAR_BITS = 16;
	localparam int CH_W      = 16;
	localparam int HASH_W    = 32;

	localparam logic [CHAR_BITS-1:0] NEWLINE_CODE = CHAR_BITS'(10);
	localparam logic [CHAR_BITS-1:0] SPACE_CODE   = CHAR_BITS'(32);
	localparam logic [CHAR_BITS-1:0] TAB_CODE     = CHAR_BITS'(9);
	localparam logic [CHAR_BITS-1:0] VT_CODE      = CHAR_BITS'(11);
	localparam logic [CHAR_BITS-1:0] FF_CODE      = CHAR_BITS'(12);
	localparam logic [CHAR_BITS-1:0] CR_CODE      = CHAR_BITS'(13);
	localparam logic [CHAR_BITS-1:0] UPPER_A      = CHAR_BITS'(65);
	localparam logic [CHAR_BITS-1:0] UPPER_Z      = CHAR_BITS'(90);
	localparam logic [CHAR_BITS-1:0] CASE_OFFSET  = CHAR_BITS'(32);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IGNORE_CASE = 2'd0,
		REG_SPACE_MODE  = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_EXACT         = 2'd0,
		MODE_IGNORE_ALL    = 2'd1,
		MODE_IGNORE_CHANGE = 2'd2,
		MODE_BOTH          = 2'd3
	} space_mode_t;

	// Operation decided by the front end for each character
	typedef enum logic [2:0] {
		OP_NEWLINE     = 3'd0,
		OP_HASH        = 3'd1,
		OP_SKIP        = 3'd2,
		OP_WS_CHANGE   = 3'd3,
		OP_HASH_CHANGE = 3'd4
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [CHAR_BITS-1:0] c;
	} entry_t;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic               empty;
		logic               full;
		logic [Q_CNT_W-1:0] count;
	} qstat_t;

	function automatic logic is_white(input logic [CHAR_BITS-1:0] c);
		return (c == SPACE_CODE) || (c == TAB_CODE) || (c == VT_CODE) ||
			(c == FF_CODE) || (c == CR_CODE);
	endfunction

	function automatic logic [CHAR_BITS-1:0] fold_case(input logic [CHAR_BITS-1:0] c,
		input logic en);
		logic [CHAR_BITS-1:0] r;
		r = c;
		if (en && (c >= UPPER_A) && (c <= UPPER_Z)) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

// ----- sv/lhwn_if.sv -----
// Handshake channel interfaces: characters in, line hashes out, register writes.
interface lhwn_ch_if;
	import lhwn_pkg::*;
	logic                valid;
	logic                ready;
	logic [CH_W-1:0]     ch;
	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

interface lhwn_hash_if;
	import lhwn_pkg::*;
	logic                valid;
	logic                ready;
	logic [HASH_W-1:0]   line_hash;
	modport source (output valid, output line_hash, input ready);
	modport sink   (input valid, input line_hash, output ready);
endinterface

interface lhwn_cfg_if;
	import lhwn_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] wdata;
	modport source (output valid, output idx, output wdata, input ready);
	modport sink   (input valid, input idx, input wdata, output ready);
endinterface

// ----- sv/lhwn_front.sv -----
// Front end: configuration registers, character accept and classification.
module lhwn_front
	import lhwn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lhwn_ch_if.sink     in_ch,
	lhwn_cfg_if.sink    cfg,
	input  qstat_t      qstat,
	output logic        push,
	output entry_t      push_entry
);

	logic                 ignore_case_q;
	logic [1:0]           space_mode_q;
	logic [CHAR_BITS-1:0] c;
	logic                 white;
	space_mode_t          mode;

	// Register writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_case_q <= 1'b0;
			space_mode_q  <= MODE_EXACT;
		end else if (cfg.valid) begin
			if (cfg.idx == REG_IGNORE_CASE) begin
				ignore_case_q <= cfg.wdata[0];
			end else if (cfg.idx == REG_SPACE_MODE) begin
				space_mode_q <= cfg.wdata[1:0];
			end
		end
	end

	// Accept whenever the queue has room
	assign in_ch.ready = !qstat.full;
	assign push        = in_ch.valid && !qstat.full;

	assign c     = in_ch.ch[CHAR_BITS-1:0];
	assign white = is_white(c);
	assign mode  = space_mode_t'(space_mode_q);

	// Classify the character under the current mode; MODE_BOTH acts as ignore-all
	always_comb begin
		push_entry.c = fold_case(c, ignore_case_q);
		if (c == NEWLINE_CODE) begin
			push_entry.op = OP_NEWLINE;
		end else begin
			unique case (mode)
				MODE_EXACT:         push_entry.op = OP_HASH;
				MODE_IGNORE_CHANGE: push_entry.op = white ? OP_WS_CHANGE : OP_HASH_CHANGE;
				MODE_IGNORE_ALL,
				MODE_BOTH:          push_entry.op = white ? OP_SKIP : OP_HASH;
				default:            push_entry.op = OP_HASH;
			endcase
		end
	end

endmodule

// ----- sv/lhwn_queue.sv -----
// Small FIFO of classified characters between front and back.
module lhwn_queue
	import lhwn_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output qstat_t qstat
);

	entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	// Storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign qstat.count = count_q;

endmodule

// ----- sv/lhwn_back.sv -----
// Back end: line state, hash update and output register.
module lhwn_back
	import lhwn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      head,
	input  qstat_t      qstat,
	output logic        pop,
	lhwn_hash_if.source out_hash
);

	logic [HASH_W-1:0] hash_q;
	logic              space_pending_q;
	logic              at_line_start_q;
	logic              out_valid_q;
	logic [HASH_W-1:0] line_hash_q;

	logic [HASH_W-1:0] h_pre;
	logic [HASH_W-1:0] h_next;
	logic              add_space;

	// A newline needs the output slot free or draining
	assign pop = !qstat.empty &&
		((head.op != OP_NEWLINE) || !out_valid_q || out_hash.ready);

	// Optional pending space, then the character: h = 5h + c twice at most
	assign add_space = (head.op == OP_HASH_CHANGE) && space_pending_q;
	assign h_pre  = add_space ? ((hash_q << 2) + hash_q + HASH_W'(SPACE_CODE)) : hash_q;
	assign h_next = (h_pre << 2) + h_pre + HASH_W'(head.c);

	// Line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q          <= '0;
			space_pending_q <= 1'b0;
			at_line_start_q <= 1'b1;
		end else if (pop) begin
			unique case (head.op)
				OP_NEWLINE: begin
					hash_q          <= '0;
					space_pending_q <= 1'b0;
					at_line_start_q <= 1'b1;
				end
				OP_HASH, OP_HASH_CHANGE: begin
					hash_q          <= h_next;
					space_pending_q <= 1'b0;
					at_line_start_q <= 1'b0;
				end
				OP_SKIP: begin
					space_pending_q <= 1'b0;
				end
				OP_WS_CHANGE: begin
					if (!at_line_start_q) begin
						space_pending_q <= 1'b1;
					end
				end
				default: begin
					space_pending_q <= space_pending_q;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && (head.op == OP_NEWLINE)) begin
			out_valid_q <= 1'b1;
		end else if (out_hash.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (head.op == OP_NEWLINE)) begin
			line_hash_q <= hash_q;
		end
	end

	assign out_hash.valid     = out_valid_q;
	assign out_hash.line_hash = line_hash_q;

endmodule

// ----- sv/line_hash_whitespace_normalizer.sv -----
// Top level of the line hash normalizer: front end, queue, back end.
// Takes one character per cycle while the queue has room, and keeps a running 32-bit hash
// (h = 5h + c) of the current line. On a newline the line hash passes through the queue
// and then sits in the output register, where out_hash shows it; the newline waits in
// the queue while an earlier result is still waiting and not being taken.
// Other characters give no result. The rate is one character per cycle while the queue
// has room, set by the back end's hash update, which handles a pending collapsed space
// and the character together. A four-entry queue lets input keep flowing while a result
// waits; in_ch.ready drops only when that queue is full. Register writes (index 0 case fold,
// index 1 space mode) are always ready and should be made while the block is idle.
module line_hash_whitespace_normalizer
	import lhwn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lhwn_ch_if.sink     in_ch,
	lhwn_hash_if.source out_hash,
	lhwn_cfg_if.sink    cfg
);

	qstat_t qstat;
	logic   push;
	logic   pop;
	entry_t push_entry;
	entry_t head;

	lhwn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	lhwn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	lhwn_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.out_hash (out_hash)
	);

`ifndef SYNTHESIS
	// Queue fill never exceeds its depth
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count above depth");

	// Never read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	// A newline never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (head.op == OP_NEWLINE)) |-> (!out_hash.valid || out_hash.ready))
		else $error("result overwritten");

	// A newline taken by the back end shows a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (head.op == OP_NEWLINE)) |=> out_hash.valid)
		else $error("newline gave no result");
`endif

endmodule
